@@ rtl/cfah_pkg.sv @@
// ----------------------------------------------------------------------------
// Case-folded Adler hash package
// Shared item type, hash constants and the per-byte arithmetic helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package cfah_pkg;

  // Modulus of both running sums and the position of the high sum in the word.
  localparam logic [15:0] HashModulus = 16'd65521;
  localparam int unsigned HighShift   = 16;
  localparam int unsigned SumWidth    = 16;
  localparam int unsigned HashWidth   = 2 * SumWidth;

  // ASCII upper-case range and the offset to lower case.
  localparam logic [7:0] UpperFirst = 8'h41;
  localparam logic [7:0] UpperLast  = 8'h5A;
  localparam logic [7:0] CaseOffset = 8'h20;

  // One input item as held in the input register.
  typedef struct packed {
    logic       final_byte;
    logic [7:0] text_byte;
  } cfah_item_t;

  // Fold ASCII A to Z onto a to z; every other code passes unchanged.
  function automatic logic [7:0] fold_lower(input logic [7:0] b);
    logic [7:0] r;
    r = b;
    if (b >= UpperFirst && b <= UpperLast) begin
      r = b + CaseOffset;
    end
    return r;
  endfunction

  // Add two residues below the modulus with one conditional subtraction.
  function automatic logic [SumWidth-1:0] mod_add(input logic [SumWidth-1:0] a,
                                                  input logic [SumWidth-1:0] b);
    logic [SumWidth:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, HashModulus}) begin
      s = s - {1'b0, HashModulus};
    end
    return s[SumWidth-1:0];
  endfunction

endpackage

`default_nettype wire

@@ rtl/case_folded_adler_hash_top.sv @@
// ----------------------------------------------------------------------------
// Case-folded Adler hash, top level
// Hashes a byte string with two running sums modulo 65521 after folding
// ASCII upper case to lower case; emits one hash word per string.
//
//   Channel   Direction  tdata bits (low up)        Side bits
//   s_axis    in         [7:0] text_byte            tlast = final_byte
//   m_axis    out        [31:0] hash_word           none
//
// One byte is accepted every cycle while no final byte waits in the input
// register; a final byte loads its hash word into the result register at
// the edge where it leaves the input register, and the word is held there
// until the output side takes it.
// Throughput is set by the single sum-update path between the two registers.
// Reset is asynchronous and active low; it clears both sums and all valid bits.
// A final byte waits in the input register only while an untaken hash word
// still fills the result register; non-final bytes never wait on the output.
// ----------------------------------------------------------------------------
`default_nettype none

module case_folded_adler_hash_top (
  input  wire         clk_i,
  input  wire         rst_ni,
  // Input stream: tdata = text_byte[7:0]; tlast = final_byte.
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [7:0]  s_axis_tdata,
  input  wire         s_axis_tlast,
  // Output stream: tdata = hash_word[31:0].
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [31:0] m_axis_tdata
);

  cfah_pkg::cfah_item_t           in_item, st_item;
  logic                           st_valid;
  logic                           st_take;
  logic                           out_free;
  logic [cfah_pkg::HashWidth-1:0] hash_word;

  assign in_item.text_byte  = s_axis_tdata;
  assign in_item.final_byte = s_axis_tlast;

  // Input register.
  cfah_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .item_i  (in_item),
    .valid_o (st_valid),
    .take_i  (st_take),
    .item_o  (st_item)
  );

  // A held byte is consumed unless it is final and the result register is full and not being taken.
  assign st_take = st_valid && (!st_item.final_byte || out_free);

  // Running sums.
  cfah_accum u_accum (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (st_take),
    .item_i (st_item),
    .hash_o (hash_word)
  );

  // Result register.
  cfah_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (st_take && st_item.final_byte),
    .data_i  (hash_word),
    .free_o  (out_free),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .data_o  (m_axis_tdata)
  );

endmodule

`default_nettype wire

@@ rtl/cfah_in_reg.sv @@
// ----------------------------------------------------------------------------
// Case-folded Adler hash input register
// Registers one incoming byte transaction and holds it until it is consumed.
// ----------------------------------------------------------------------------
`default_nettype none

module cfah_in_reg (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       valid_i,
  output logic                      ready_o,
  input  wire cfah_pkg::cfah_item_t item_i,
  output logic                      valid_o,
  input  wire                       take_i,
  output cfah_pkg::cfah_item_t      item_o
);

  logic                 valid_d, valid_q;
  cfah_pkg::cfah_item_t item_q;

  // The stage is free when empty or when its item leaves this cycle.
  assign ready_o = !valid_q || take_i;

  always_comb begin
    valid_d = valid_q;
    if (ready_o) begin
      valid_d = valid_i;
    end
  end

  // Control bit under reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload is loaded on every accepted transaction.
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire

@@ rtl/cfah_accum.sv @@
// ----------------------------------------------------------------------------
// Case-folded Adler hash accumulator
// Holds the low and high running sums and updates them once per byte.
// ----------------------------------------------------------------------------
`default_nettype none

module cfah_accum (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               go_i,
  input  wire cfah_pkg::cfah_item_t         item_i,
  output logic [cfah_pkg::HashWidth-1:0]    hash_o
);

  logic [cfah_pkg::SumWidth-1:0] low_sum_d, low_sum_q;
  logic [cfah_pkg::SumWidth-1:0] high_sum_d, high_sum_q;
  logic [cfah_pkg::SumWidth-1:0] low_next, high_next;

  // Fold the byte, add it to the low sum, then add the new low sum to the high sum.
  always_comb begin
    low_next  = cfah_pkg::mod_add(low_sum_q,
                                  {{(cfah_pkg::SumWidth-8){1'b0}},
                                   cfah_pkg::fold_lower(item_i.text_byte)});
    high_next = cfah_pkg::mod_add(high_sum_q, low_next);
  end

  assign hash_o = {high_next, low_next};

  // A final byte clears both sums for the next string.
  always_comb begin
    low_sum_d  = low_sum_q;
    high_sum_d = high_sum_q;
    if (go_i) begin
      if (item_i.final_byte) begin
        low_sum_d  = '0;
        high_sum_d = '0;
      end else begin
        low_sum_d  = low_next;
        high_sum_d = high_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_sum_q  <= '0;
      high_sum_q <= '0;
    end else begin
      low_sum_q  <= low_sum_d;
      high_sum_q <= high_sum_d;
    end
  end

`ifndef ASSERT_OFF
  // Both sums stay proper residues.
  a_low_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    low_sum_q < cfah_pkg::HashModulus)
    else $error("low sum left the residue range");

  a_high_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    high_sum_q < cfah_pkg::HashModulus)
    else $error("high sum left the residue range");

  // A consumed final byte leaves both sums cleared.
  a_clear_on_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    go_i && item_i.final_byte |=> low_sum_q == '0 && high_sum_q == '0)
    else $error("sums not cleared after final byte");

  // Without a consumed byte the sums hold.
  a_hold_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !go_i |=> $stable(low_sum_q) && $stable(high_sum_q))
    else $error("sums changed without a byte");
`endif

endmodule

`default_nettype wire

@@ rtl/cfah_out_reg.sv @@
// ----------------------------------------------------------------------------
// Case-folded Adler hash result register
// Holds a finished hash word until the downstream side takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module cfah_out_reg (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               load_i,
  input  wire [cfah_pkg::HashWidth-1:0]     data_i,
  output logic                              free_o,
  output logic                              valid_o,
  input  wire                               ready_i,
  output logic [cfah_pkg::HashWidth-1:0]    data_o
);

  logic                           valid_d, valid_q;
  logic [cfah_pkg::HashWidth-1:0] data_q;

  // Room for a new word when empty or when the held word is taken now.
  assign free_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    if (free_o) begin
      valid_d = load_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_o && load_i) begin
      data_q <= data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Case-folded Adler hash testbench
// Streams byte strings into the hash block and compares every hash word with
// a cycle-free model of the two running sums. A short table of directed
// strings comes first. Random strings follow under several idling patterns,
// with one long output hold-off that backs the block up into its input.
// ----------------------------------------------------------------------------

module testbench;

  localparam int HalfPeriod  = 10;
  localparam int ResetCycles = 5;
  localparam int PhaseBytes  = 160;
  localparam int HoldCycles  = 200;
  localparam int DrainCycles = 8;
  localparam int LongLenMin  = 400;
  localparam int LongLenMax  = 700;
  localparam int TimeoutNs   = 5_000_000;

  // One directed byte; a hash is typed in only where it is obvious.
  typedef struct {
    logic [7:0]                     text;
    logic                           last;
    bit                             known;
    logic [cfah_pkg::HashWidth-1:0] hash;
  } hash_row_t;

  logic                           clk_i         = 1'b0;
  logic                           rst_ni        = 1'b0;
  logic                           s_axis_tvalid = 1'b0;
  logic [7:0]                     s_axis_tdata  = '0;
  logic                           s_axis_tlast  = 1'b0;
  wire                            s_axis_tready;
  wire                            m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  wire  [cfah_pkg::HashWidth-1:0] m_axis_tdata;

  // Model state: running sums and the hash words still to arrive.
  logic [cfah_pkg::SumWidth-1:0]  low_acc  = '0;
  logic [cfah_pkg::SumWidth-1:0]  high_acc = '0;
  logic [cfah_pkg::HashWidth-1:0] expected_hashes[$];

  int errors             = 0;
  int bytes_sent         = 0;
  int sender_idle_pct    = 0;
  int receiver_stall_pct = 0;
  int hold_requests      = 0;
  int holds_served       = 0;
  int hold_left          = 0;

  // Single-character strings hash to the folded byte in both halves.
  hash_row_t directed_rows [21] = '{
    '{8'h41, 1'b1, 1'b1, 32'h0061_0061},
    '{8'h5A, 1'b1, 1'b1, 32'h007A_007A},
    '{8'h40, 1'b1, 1'b1, 32'h0040_0040},
    '{8'h5B, 1'b1, 1'b1, 32'h005B_005B},
    '{8'h00, 1'b1, 1'b1, 32'h0000_0000},
    '{8'hFF, 1'b1, 1'b1, 32'h00FF_00FF},
    '{8'h80, 1'b1, 1'b1, 32'h0080_0080},
    '{8'h61, 1'b1, 1'b1, 32'h0061_0061},
    '{8'h7A, 1'b1, 1'b1, 32'h007A_007A},
    '{8'h41, 1'b0, 1'b0, '0},
    '{8'h62, 1'b0, 1'b0, '0},
    '{8'h43, 1'b1, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b1, 1'b0, '0},
    '{8'h7F, 1'b0, 1'b0, '0},
    '{8'h4D, 1'b0, 1'b0, '0},
    '{8'h01, 1'b1, 1'b0, '0},
    '{8'h01, 1'b1, 1'b1, 32'h0001_0001},
    '{8'hAA, 1'b1, 1'b1, 32'h00AA_00AA}
  };

  case_folded_adler_hash_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // [7:0] text_byte
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)    // [31:0] hash_word
  );

  always begin
    #HalfPeriod clk_i = 1'b1;
    #HalfPeriod clk_i = 1'b0;
  end

  // Fold one byte into the running sums; a last byte yields the hash word.
  function automatic void absorb_byte(input logic [7:0] b, input logic last,
                                      output logic done,
                                      output logic [cfah_pkg::HashWidth-1:0] word);
    logic [7:0]                  folded;
    logic [cfah_pkg::SumWidth:0] acc;
    folded = (b >= cfah_pkg::UpperFirst && b <= cfah_pkg::UpperLast) ?
             b + cfah_pkg::CaseOffset : b;
    acc = {1'b0, low_acc} + {{(cfah_pkg::SumWidth-7){1'b0}}, folded};
    if (acc >= {1'b0, cfah_pkg::HashModulus}) acc = acc - {1'b0, cfah_pkg::HashModulus};
    low_acc = acc[cfah_pkg::SumWidth-1:0];
    acc = {1'b0, high_acc} + {1'b0, low_acc};
    if (acc >= {1'b0, cfah_pkg::HashModulus}) acc = acc - {1'b0, cfah_pkg::HashModulus};
    high_acc = acc[cfah_pkg::SumWidth-1:0];
    word = {high_acc, low_acc};
    done = last;
    if (last) begin
      low_acc  = '0;
      high_acc = '0;
    end
  endfunction

  // Offer one byte after a random gap and wait for its transaction.
  task automatic send_byte(input logic [7:0] b, input logic last, input bit known,
                           input logic [cfah_pkg::HashWidth-1:0] hash);
    logic                           done;
    logic [cfah_pkg::HashWidth-1:0] word;
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    absorb_byte(b, last, done, word);
    if (done) expected_hashes = {expected_hashes, (known ? hash : word)};
    bytes_sent++;
  endtask

  // A heavy string uses high bytes only, so that the low sum wraps.
  task automatic send_string(input int len, input bit heavy);
    logic [7:0] b;
    for (int k = 0; k < len; k++) begin
      if (heavy) begin
        b = 8'($urandom_range(160, 255));
      end else begin
        case ($urandom_range(0, 3))
          0, 1: b = 8'($urandom_range(0, 255));
          2:    b = 8'($urandom_range(cfah_pkg::UpperFirst, cfah_pkg::UpperLast));
          default: b = 8'($urandom_range(cfah_pkg::UpperFirst + cfah_pkg::CaseOffset,
                                         cfah_pkg::UpperLast + cfah_pkg::CaseOffset));
        endcase
      end
      send_byte(b, k == len - 1, 1'b0, '0);
    end
  endtask

  // Random strings, mostly short, under one idling pattern.
  task automatic run_phase(input int idle_pct, input int stall_pct, input int n_bytes);
    int stop_at;
    int pick;
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 80) send_string($urandom_range(1, 8), 1'b0);
      else send_string($urandom_range(9, 40), 1'b0);
    end
  endtask

  // Output side: check each hash transaction, then choose the next tready.
  always @(posedge clk_i) begin : take_hash
    logic [cfah_pkg::HashWidth-1:0] want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_hashes.size() == 0) begin
        errors++;
        $error("hash_word arrived with none expected: actual %h", m_axis_tdata);
      end else begin
        want = expected_hashes.pop_front();
        if (m_axis_tdata !== want) begin
          errors++;
          $error("hash_word mismatch: expected %h, actual %h", want, m_axis_tdata);
        end
      end
    end
    if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_left     <= hold_left - 1;
    end else if (hold_requests != holds_served) begin
      m_axis_tready <= 1'b0;
      holds_served  <= hold_requests;
      hold_left     <= HoldCycles;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
    end
  end

  initial begin
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      send_byte(directed_rows[i].text, directed_rows[i].last,
                directed_rows[i].known, directed_rows[i].hash);
    end

    // Random part; one long string up front makes the sums wrap, the high sum for certain.
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    send_string($urandom_range(LongLenMin, LongLenMax), 1'b1);
    run_phase(0, 0, PhaseBytes);
    run_phase(84, 0, PhaseBytes);
    run_phase(0, 84, PhaseBytes);
    run_phase(30, 30, PhaseBytes);

    // Long output hold-off while short strings keep coming.
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    hold_requests++;
    for (int n = 0; n < 60; n++) send_string($urandom_range(1, 2), 1'b0);
    run_phase(0, 0, 150);

    s_axis_tvalid <= 1'b0;
    while (expected_hashes.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Run limit.
  initial begin
    #(TimeoutNs);
    $display("simulation failed");
    $finish;
  end

endmodule

@@ files.f @@
rtl/cfah_pkg.sv
rtl/cfah_in_reg.sv
rtl/cfah_accum.sv
rtl/cfah_out_reg.sv
rtl/case_folded_adler_hash_top.sv
tb/testbench.sv
